// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on rising edge, reset disables
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle whenever the antecedent is true
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// shared types and constants of the 4x4 transform unit
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int DATA_W = 32;
  localparam int VEC_N  = 4;
  localparam int IDX_W  = 2;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  typedef logic [DATA_W-1:0] word_t;

  localparam word_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // one item as it travels down the cell chain
  typedef struct packed {
    logic                    xf;
    logic [IDX_W-1:0]        col;
    logic [IDX_W-1:0]        row;
    word_t                   value;
    word_t [VEC_N-1:0]       vec;
  } item_t;

endpackage

// File: hdl/mvt_in_if.sv
// ----------------------------------------------------------------------------
// mvt_in_if
// input channel: coefficient load or vector transform item
// ----------------------------------------------------------------------------
interface mvt_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [1:0]               entry_col;
  logic [1:0]               entry_row;
  logic signed [31:0]       entry_value;
  logic signed [31:0]       vec_x;
  logic signed [31:0]       vec_y;
  logic signed [31:0]       vec_z;
  logic signed [31:0]       vec_w;

  modport source (
    output valid, op, entry_col, entry_row, entry_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );

  modport sink (
    input  valid, op, entry_col, entry_row, entry_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

// File: hdl/mvt_out_if.sv
// ----------------------------------------------------------------------------
// mvt_out_if
// result channel: transformed vector and saturation flag
// ----------------------------------------------------------------------------
interface mvt_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       out_x;
  logic signed [31:0]       out_y;
  logic signed [31:0]       out_z;
  logic signed [31:0]       out_w;
  logic                     overflow;

  modport source (
    output valid, out_x, out_y, out_z, out_w, overflow,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, out_w, overflow,
    output ready
  );
endinterface

// File: hdl/mvt_cell.sv
// ----------------------------------------------------------------------------
// mvt_cell
// one matrix column: holds four coefficients, multiplies by its vector
// component and adds the products into the passing partial sums
// ----------------------------------------------------------------------------
module mvt_cell #(
  parameter int CW   = 32,
  parameter int SUMW = 66,
  parameter int COL  = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  mvt_pkg::item_t         up_item,
  input  logic signed [SUMW-1:0] up_sum [mvt_pkg::VEC_N],
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output mvt_pkg::item_t         dn_item,
  output logic signed [SUMW-1:0] dn_sum [mvt_pkg::VEC_N]
);

  localparam int PW = CW + mvt_pkg::DATA_W;
  localparam logic [mvt_pkg::IDX_W-1:0] COL_IDX = mvt_pkg::IDX_W'(COL);

  logic signed [CW-1:0]          coef_r   [mvt_pkg::VEC_N];
  logic signed [mvt_pkg::DATA_W-1:0] vj;
  logic signed [PW-1:0]          prod_nxt [mvt_pkg::VEC_N];

  logic                          a_valid_r;
  mvt_pkg::item_t                a_item_r;
  logic signed [SUMW-1:0]        a_sum_r  [mvt_pkg::VEC_N];
  logic signed [PW-1:0]          a_prod_r [mvt_pkg::VEC_N];

  logic                          b_valid_r;
  mvt_pkg::item_t                b_item_r;
  logic signed [SUMW-1:0]        b_sum_r  [mvt_pkg::VEC_N];

  logic a_ready, b_ready, a_load, b_load, coef_wr;

  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;
  assign a_load   = up_valid && a_ready;
  assign b_load   = a_valid_r && b_ready;
  // a load item writes when it passes the cell that owns its column
  assign coef_wr  = a_load && (up_item.xf == mvt_pkg::OP_LOAD) && (up_item.col == COL_IDX);

  assign vj = up_item.vec[COL];

  always_comb begin
    for (int i = 0; i < mvt_pkg::VEC_N; i++) begin
      prod_nxt[i] = PW'(coef_r[i]) * PW'(vj);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      for (int i = 0; i < mvt_pkg::VEC_N; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (coef_wr) begin
        coef_r[up_item.row] <= up_item.value[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_item_r <= up_item;
      for (int i = 0; i < mvt_pkg::VEC_N; i++) begin
        a_sum_r[i]  <= up_sum[i];
        a_prod_r[i] <= prod_nxt[i];
      end
    end
    if (b_load) begin
      b_item_r <= a_item_r;
      for (int i = 0; i < mvt_pkg::VEC_N; i++) begin
        b_sum_r[i] <= a_sum_r[i] + SUMW'(a_prod_r[i]);
      end
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_item  = b_item_r;
  assign dn_sum   = b_sum_r;

endmodule

// File: hdl/mvt_sat.sv
// ----------------------------------------------------------------------------
// mvt_sat
// drops load items, scales the sums by the fraction bits, saturates to
// 32 bits and holds the result in the output register
// ----------------------------------------------------------------------------
module mvt_sat #(
  parameter int SUMW      = 66,
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  mvt_pkg::item_t         up_item,
  input  logic signed [SUMW-1:0] up_sum [mvt_pkg::VEC_N],
  mvt_out_if.source              out_ch
);

  localparam int OW = mvt_pkg::DATA_W;
  localparam logic signed [SUMW-1:0] MAXV = {{(SUMW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] MINV = {{(SUMW-OW+1){1'b1}}, {(OW-1){1'b0}}};

  logic signed [SUMW-1:0] sh      [mvt_pkg::VEC_N];
  mvt_pkg::word_t         res_nxt [mvt_pkg::VEC_N];
  logic [mvt_pkg::VEC_N-1:0] sat;

  logic                   out_valid_r;
  mvt_pkg::word_t         res_r [mvt_pkg::VEC_N];
  logic                   ovf_r;
  logic                   load;

  always_comb begin
    for (int i = 0; i < mvt_pkg::VEC_N; i++) begin
      sh[i] = up_sum[i] >>> FRAC_BITS;
      if (sh[i] > MAXV) begin
        res_nxt[i] = mvt_pkg::SAT_MAX;
        sat[i]     = 1'b1;
      end else if (sh[i] < MINV) begin
        res_nxt[i] = mvt_pkg::SAT_MIN;
        sat[i]     = 1'b1;
      end else begin
        res_nxt[i] = sh[i][OW-1:0];
        sat[i]     = 1'b0;
      end
    end
  end

  assign up_ready = !out_valid_r || out_ch.ready;
  assign load     = up_valid && up_ready && (up_item.xf == mvt_pkg::OP_TRANSFORM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid && (up_item.xf == mvt_pkg::OP_TRANSFORM);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
      ovf_r <= |sat;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_x    = res_r[0];
  assign out_ch.out_y    = res_r[1];
  assign out_ch.out_z    = res_r[2];
  assign out_ch.out_w    = res_r[3];
  assign out_ch.overflow = ovf_r;

endmodule

// File: hdl/mat4_vector_transform.sv
// ----------------------------------------------------------------------------
// mat4_vector_transform
// 4x4 fixed-point matrix times vector, built as a chain of column cells
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch (valid/ready). op = 0 loads one Q15.16
// coefficient at (entry_col, entry_row); op = 1 transforms the vector
// vec_x..vec_w. Each transform gives one transfer on out_ch with the four
// saturated Q15.16 components and an overflow flag; a load gives none.
// Four cells, one per matrix column, each take two register stages: a
// multiply of the four column coefficients by that cell's vector component,
// then an add into the partial sums handed on to the next cell. A final
// stage shifts, saturates and holds the output register.
// Throughput: one item per cycle, limited only by out_ch.ready.
// Loads travel down the chain with the transforms, so every transform uses
// exactly the coefficients loaded before it.
// Reset (rst_n low, synchronous) clears all coefficients to zero and empties
// the chain. When the receiver stalls the result is held, and the chain keeps
// accepting items until every stage is full; ready then follows out_ch.ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mat4_vector_transform #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mvt_in_if.sink     in_ch,
  mvt_out_if.source  out_ch
);

  localparam int CW   = (COEF_WIDTH >= mvt_pkg::DATA_W) ? mvt_pkg::DATA_W : COEF_WIDTH;
  localparam int SUMW = CW + mvt_pkg::DATA_W + 2;
  localparam int NC   = mvt_pkg::VEC_N;

  logic                   valid_w [NC+1];
  logic                   ready_w [NC+1];
  mvt_pkg::item_t         item_w  [NC+1];
  logic signed [SUMW-1:0] sum_w   [NC+1][NC];

  assign valid_w[0]       = in_ch.valid;
  assign in_ch.ready      = ready_w[0];
  assign item_w[0].xf     = (in_ch.op == mvt_pkg::OP_TRANSFORM);
  assign item_w[0].col    = in_ch.entry_col;
  assign item_w[0].row    = in_ch.entry_row;
  assign item_w[0].value  = in_ch.entry_value;
  assign item_w[0].vec[0] = in_ch.vec_x;
  assign item_w[0].vec[1] = in_ch.vec_y;
  assign item_w[0].vec[2] = in_ch.vec_z;
  assign item_w[0].vec[3] = in_ch.vec_w;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      sum_w[0][i] = '0;
    end
  end

  for (genvar c = 0; c < NC; c++) begin : g_cell
    mvt_cell #(
      .CW   (CW),
      .SUMW (SUMW),
      .COL  (c)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_w[c]),
      .up_ready (ready_w[c]),
      .up_item  (item_w[c]),
      .up_sum   (sum_w[c]),
      .dn_valid (valid_w[c+1]),
      .dn_ready (ready_w[c+1]),
      .dn_item  (item_w[c+1]),
      .dn_sum   (sum_w[c+1])
    );
  end

  mvt_sat #(
    .SUMW      (SUMW),
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (valid_w[NC]),
    .up_ready (ready_w[NC]),
    .up_item  (item_w[NC]),
    .up_sum   (sum_w[NC]),
    .out_ch   (out_ch)
  );

  // a flagged result has at least one component pinned at a limit
  `ASSERT_SAME(a_ovf_limit, clk, rst_n, out_ch.valid && out_ch.overflow,
    out_ch.out_x == mvt_pkg::SAT_MAX || out_ch.out_x == mvt_pkg::SAT_MIN ||
    out_ch.out_y == mvt_pkg::SAT_MAX || out_ch.out_y == mvt_pkg::SAT_MIN ||
    out_ch.out_z == mvt_pkg::SAT_MAX || out_ch.out_z == mvt_pkg::SAT_MIN ||
    out_ch.out_w == mvt_pkg::SAT_MAX || out_ch.out_w == mvt_pkg::SAT_MIN,
    "overflow set without a saturated component")
  // a transform leaving the last cell always lands in the output register
  `ASSERT_NEXT(a_xf_out, clk, rst_n,
    valid_w[NC] && ready_w[NC] && item_w[NC].xf, out_ch.valid,
    "transform lost at the output stage")
  // a stalled item at the chain end stays put
  `ASSERT_NEXT(a_chain_hold, clk, rst_n, valid_w[NC] && !ready_w[NC],
    valid_w[NC] && $stable(item_w[NC].xf),
    "chain end dropped a stalled item")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the 4x4 fixed-point transform unit
// ----------------------------------------------------------------------------
// A directed table covers reset contents, identity, extreme values,
// saturation both ways, floor rounding and the column-major layout. Random
// loads and transforms follow. Each transform is predicted from a local copy
// of the coefficient bank and checked in order against the result channel.
// Both sides throttle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int COEF_W   = 32;
  localparam int FRAC     = 16;
  localparam int N_RAND   = 528;
  localparam int LIMIT    = 200_000;
  localparam int DRAIN    = 20;

  localparam mvt_pkg::word_t Q_ONE  = 32'h0001_0000;
  localparam mvt_pkg::word_t NEG1   = 32'hFFFF_FFFF;

  localparam logic signed [67:0] POS_LIM = 68'sd2147483647;
  localparam logic signed [67:0] NEG_LIM = -68'sd2147483648;

  typedef struct packed {
    mvt_pkg::word_t [mvt_pkg::VEC_N-1:0] comp;
    logic                                ovf;
  } xform_t;

  typedef struct packed {
    mvt_pkg::item_t it;
    logic           chk;
    xform_t         want;
  } row_t;

  logic clk;
  logic rst_n;

  mvt_in_if  in_ch ();
  mvt_out_if out_ch ();

  mat4_vector_transform #(
    .COEF_WIDTH (COEF_W),
    .FRAC_BITS  (FRAC)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [31:0] coef_bank [16];
  xform_t             xform_q [$];
  row_t               plan [$];
  int                 src_idle;
  int                 snk_idle;
  int                 err_cnt;
  int                 result_cnt;
  int                 cycles;
  xform_t             got;
  xform_t             want;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d transforms pending", cycles, xform_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input mvt_pkg::word_t got_v,
                                 input mvt_pkg::word_t want_v);
    $display("MISMATCH result %0d %s: got %h want %h at %0t", result_cnt, what, got_v,
             want_v, $realtime);
    err_cnt++;
  endtask

  // matrix times vector, full-width sum, floor shift, saturate to 32 bits
  function automatic xform_t apply_matrix(input mvt_pkg::word_t [mvt_pkg::VEC_N-1:0] v);
    xform_t             r;
    logic signed [67:0] acc;
    logic signed [67:0] sh;
    logic signed [31:0] c;
    logic signed [31:0] e;
    r.ovf = 1'b0;
    for (int i = 0; i < mvt_pkg::VEC_N; i++) begin
      acc = '0;
      for (int j = 0; j < mvt_pkg::VEC_N; j++) begin
        c = coef_bank[4'(j*4+i)];
        e = v[j];
        acc = acc + c * e;
      end
      sh = acc >>> FRAC;
      if (sh > POS_LIM) begin
        r.comp[i] = mvt_pkg::SAT_MAX;
        r.ovf = 1'b1;
      end else if (sh < NEG_LIM) begin
        r.comp[i] = mvt_pkg::SAT_MIN;
        r.ovf = 1'b1;
      end else begin
        r.comp[i] = sh[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] narrow_coef(input mvt_pkg::word_t value);
    if (COEF_W < 32)
      return $signed(value << (32 - COEF_W)) >>> (32 - COEF_W);
    return value;
  endfunction

  function automatic mvt_pkg::word_t rand_word();
    case ($urandom_range(9))
      0: return mvt_pkg::SAT_MAX;
      1: return mvt_pkg::SAT_MIN;
      2: return '0;
      3: return $urandom_range(1) ? Q_ONE : -Q_ONE;
      4, 5: return $urandom;
      default: return $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
  endfunction

  function automatic mvt_pkg::item_t rand_item();
    mvt_pkg::item_t it;
    it.xf    = ($urandom_range(99) < 45) ? mvt_pkg::OP_LOAD : mvt_pkg::OP_TRANSFORM;
    it.col   = 2'($urandom_range(3));
    it.row   = 2'($urandom_range(3));
    it.value = rand_word();
    for (int k = 0; k < mvt_pkg::VEC_N; k++)
      it.vec[k] = rand_word();
    return it;
  endfunction

  function automatic row_t load_row(input int col, input int row,
                                    input mvt_pkg::word_t value);
    row_t r;
    r = '0;
    r.it.xf    = mvt_pkg::OP_LOAD;
    r.it.col   = 2'(col);
    r.it.row   = 2'(row);
    r.it.value = value;
    // vector lanes carry junk, the unit must ignore them
    for (int k = 0; k < mvt_pkg::VEC_N; k++)
      r.it.vec[k] = $urandom;
    return r;
  endfunction

  function automatic row_t xform_row(input mvt_pkg::word_t x, input mvt_pkg::word_t y,
                                     input mvt_pkg::word_t z, input mvt_pkg::word_t w);
    row_t r;
    r = '0;
    r.it.xf     = mvt_pkg::OP_TRANSFORM;
    r.it.col    = 2'($urandom_range(3));
    r.it.row    = 2'($urandom_range(3));
    r.it.value  = $urandom;
    r.it.vec[0] = x;
    r.it.vec[1] = y;
    r.it.vec[2] = z;
    r.it.vec[3] = w;
    return r;
  endfunction

  function automatic row_t xform_chk(input mvt_pkg::word_t x, input mvt_pkg::word_t y,
                                     input mvt_pkg::word_t z, input mvt_pkg::word_t w,
                                     input mvt_pkg::word_t wx, input mvt_pkg::word_t wy,
                                     input mvt_pkg::word_t wz, input mvt_pkg::word_t ww,
                                     input logic wo);
    row_t r;
    r = xform_row(x, y, z, w);
    r.chk          = 1'b1;
    r.want.comp[0] = wx;
    r.want.comp[1] = wy;
    r.want.comp[2] = wz;
    r.want.comp[3] = ww;
    r.want.ovf     = wo;
    return r;
  endfunction

  // entered at a falling edge, leaves at the falling edge after the transfer
  task automatic send_item(input mvt_pkg::item_t it, input logic chk, input xform_t fixed);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= it.xf;
    in_ch.entry_col   <= it.col;
    in_ch.entry_row   <= it.row;
    in_ch.entry_value <= it.value;
    in_ch.vec_x       <= it.vec[0];
    in_ch.vec_y       <= it.vec[1];
    in_ch.vec_z       <= it.vec[2];
    in_ch.vec_w       <= it.vec[3];
    do @(posedge clk); while (!in_ch.ready);
    if (it.xf == mvt_pkg::OP_LOAD)
      coef_bank[{it.col, it.row}] = narrow_coef(it.value);
    else
      xform_q.push_back(chk ? fixed : apply_matrix(it.vec));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.comp[0] = out_ch.out_x;
      got.comp[1] = out_ch.out_y;
      got.comp[2] = out_ch.out_z;
      got.comp[3] = out_ch.out_w;
      got.ovf     = out_ch.overflow;
      if (xform_q.size() == 0) begin
        report_mismatch("with no transform pending", got.comp[0], '0);
      end else begin
        want = xform_q.pop_front();
        for (int k = 0; k < mvt_pkg::VEC_N; k++)
          if (got.comp[k] !== want.comp[k])
            report_mismatch($sformatf("component %0d", k), got.comp[k], want.comp[k]);
        if (got.ovf !== want.ovf)
          report_mismatch("overflow", 32'(got.ovf), 32'(want.ovf));
      end
      result_cnt++;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.op          = mvt_pkg::OP_LOAD;
    in_ch.entry_col   = '0;
    in_ch.entry_row   = '0;
    in_ch.entry_value = '0;
    in_ch.vec_x       = '0;
    in_ch.vec_y       = '0;
    in_ch.vec_z       = '0;
    in_ch.vec_w       = '0;
    out_ch.ready      = 1'b0;
    src_idle          = 32;
    snk_idle          = 55;
    err_cnt           = 0;
    result_cnt        = 0;
    cycles            = 0;
    for (int k = 0; k < 16; k++)
      coef_bank[k] = '0;

    // reset leaves a zero matrix
    plan.push_back(xform_chk(mvt_pkg::SAT_MAX, mvt_pkg::SAT_MIN, NEG1, 32'd1,
                             '0, '0, '0, '0, 1'b0));
    // identity passes extremes through unchanged
    plan.push_back(load_row(0, 0, Q_ONE));
    plan.push_back(load_row(1, 1, Q_ONE));
    plan.push_back(load_row(2, 2, Q_ONE));
    plan.push_back(load_row(3, 3, Q_ONE));
    plan.push_back(xform_chk(mvt_pkg::SAT_MAX, mvt_pkg::SAT_MIN, Q_ONE, NEG1,
                             mvt_pkg::SAT_MAX, mvt_pkg::SAT_MIN, Q_ONE, NEG1, 1'b0));
    // saturation both ways
    plan.push_back(load_row(0, 0, mvt_pkg::SAT_MAX));
    plan.push_back(xform_chk(mvt_pkg::SAT_MAX, '0, '0, '0,
                             mvt_pkg::SAT_MAX, '0, '0, '0, 1'b1));
    plan.push_back(xform_chk(mvt_pkg::SAT_MIN, '0, '0, '0,
                             mvt_pkg::SAT_MIN, '0, '0, '0, 1'b1));
    // the shift floors toward minus infinity
    plan.push_back(load_row(1, 1, 32'd1));
    plan.push_back(xform_chk('0, NEG1, '0, '0, '0, NEG1, '0, '0, 1'b0));
    plan.push_back(xform_chk('0, 32'd1, '0, '0, '0, '0, '0, '0, 1'b0));
    // column-major: column 3 row 0 feeds out_x from vec_w
    plan.push_back(load_row(3, 0, mvt_pkg::SAT_MIN));
    plan.push_back(xform_row('0, '0, '0, 32'd1));
    plan.push_back(xform_row('0, '0, '0, NEG1));
    // four largest products in one sum need the full width
    plan.push_back(load_row(0, 1, mvt_pkg::SAT_MIN));
    plan.push_back(load_row(1, 1, mvt_pkg::SAT_MIN));
    plan.push_back(load_row(2, 1, mvt_pkg::SAT_MIN));
    plan.push_back(load_row(3, 1, mvt_pkg::SAT_MIN));
    plan.push_back(xform_row(mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN,
                             mvt_pkg::SAT_MIN));
    plan.push_back(xform_row(mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX,
                             mvt_pkg::SAT_MAX));
    plan.push_back(load_row(0, 0, '0));
    plan.push_back(xform_row(mvt_pkg::SAT_MAX, '0, '0, '0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k])
      send_item(plan[k].it, plan[k].chk, plan[k].want);

    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 32 : (phase == 1) ? 55 : 0;
      snk_idle = (phase == 0) ? 55 : (phase == 1) ? 32 : 0;
      repeat (N_RAND / 3)
        send_item(rand_item(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (xform_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/mvt_pkg.sv
hdl/mvt_in_if.sv
hdl/mvt_out_if.sv
hdl/mvt_cell.sv
hdl/mvt_sat.sv
hdl/mat4_vector_transform.sv
tb/tb.sv
